// ----- sv/tcw_pkg.sv -----
// Package for the text console writer: screen geometry, character and mode codes,
// and the structs passed between the sequencer, the cursor logic and the store.
// No dependencies.
package tcw_pkg;

    localparam int COLUMNS   = 80;
    localparam int ROWS      = 25;
    localparam int CELLS     = ROWS * COLUMNS;
    localparam int LAST_BASE = (ROWS - 1) * COLUMNS;

    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int POS_W  = 11;
    localparam int DATA_W = 16;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int MODE_W = 2;
    localparam int IDX_W  = 11;

    localparam int PADDR_W  = 1;
    localparam int APB_W    = 32;
    localparam int TAB_STEP = 8;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;
    localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
    localparam logic [CHAR_W-1:0] CH_BS      = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF      = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
    localparam logic [CHAR_W-1:0] PRINT_LO   = 8'h20;
    localparam logic [CHAR_W-1:0] PRINT_HI   = 8'h7F;

    localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

    localparam logic [PADDR_W-1:0] REG_ATTR = 1'b0;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic              scroll;
        logic              we;
        logic [ADDR_W-1:0] waddr;
    } t_put;

endpackage

// ----- sv/tcw_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/tcw_cursor.sv -----
// Cursor update for one put item: control bytes, printable write, wrap and scroll.
// Depends on tcw_pkg.
module tcw_cursor
    import tcw_pkg::*;
(
    input  logic [COL_W-1:0]  i_col,
    input  logic [ROW_W-1:0]  i_row,
    input  logic [CHAR_W-1:0] i_char,
    output t_put              o_put
);

    localparam logic [COL_W:0] COL_LIM  = (COL_W + 1)'(COLUMNS);
    localparam logic [COL_W:0] TAB_ADD  = (COL_W + 1)'(TAB_STEP);
    localparam logic [COL_W:0] TAB_MASK = ~((COL_W + 1)'(TAB_STEP - 1));
    localparam logic [ROW_W:0] ROW_LIM  = (ROW_W + 1)'(ROWS);

    logic [COL_W:0] col_x;
    logic [ROW_W:0] row_x;
    logic           printable;

    always_comb begin
        col_x     = {1'b0, i_col};
        row_x     = {1'b0, i_row};
        printable = (i_char >= PRINT_LO) && (i_char <= PRINT_HI);
        if (i_char == CH_BS && i_col != '0) begin
            col_x = col_x - (COL_W + 1)'(1);
        end else if (i_char == CH_TAB) begin
            col_x = (col_x + TAB_ADD) & TAB_MASK;
        end else if (i_char == CH_CR) begin
            col_x = '0;
        end else if (i_char == CH_LF) begin
            col_x = '0;
            row_x = row_x + (ROW_W + 1)'(1);
        end else if (printable) begin
            col_x = col_x + (COL_W + 1)'(1);
        end
        if (col_x >= COL_LIM) begin
            col_x = '0;
            row_x = row_x + (ROW_W + 1)'(1);
        end
        o_put.we     = printable;
        o_put.waddr  = ADDR_W'(int'(i_row) * COLUMNS + int'(i_col));
        o_put.col    = col_x[COL_W-1:0];
        o_put.scroll = row_x >= ROW_LIM;
        o_put.row    = o_put.scroll ? ROW_W'(ROWS - 1) : row_x[ROW_W-1:0];
    end

endmodule

// ----- sv/tcw_seq.sv -----
// Item sequencer: accepts items, sweeps the screen store for clear, scroll and
// the reset blanking pass, and holds the result register. Depends on tcw_pkg, tcw_cursor.
module tcw_seq
    import tcw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic [IDX_W-1:0]  i_cell_index,
    input  logic [ATTR_W-1:0] i_attr,
    output t_mem_req          o_mem,
    input  logic [DATA_W-1:0] i_rdata,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [POS_W-1:0]  o_cursor_position,
    output logic [DATA_W-1:0] o_cell_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_COPY = 3'd1;
    localparam logic [2:0] S_FILL = 3'd2;
    localparam logic [2:0] S_RDWT = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [ADDR_W-1:0] r_ptr, n_ptr;
    logic              r_wr_pend, n_wr_pend;
    logic [ADDR_W-1:0] r_wr_addr, n_wr_addr;
    logic              r_init, n_init;
    logic [ATTR_W-1:0] r_fill_attr, n_fill_attr;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic              r_rd_ok, n_rd_ok;
    logic [DATA_W-1:0] r_data, n_data;
    logic              r_out_vld, n_out_vld;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [DATA_W-1:0] r_out_data, n_out_data;

    logic              in_acc;
    logic              out_free;
    logic              in_range;
    logic [ADDR_W-1:0] ptr_inc;
    logic [ADDR_W-1:0] src;
    t_put              put;

    tcw_cursor u_cursor (
        .i_col  (r_col),
        .i_row  (r_row),
        .i_char (i_char_code),
        .o_put  (put)
    );

    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = r_state != S_IDLE;
    assign out_free   = !r_out_vld || !i_out_stall;
    assign in_range   = int'(i_cell_index) < CELLS;
    assign ptr_inc    = r_ptr + ADDR_W'(1);
    assign src        = r_ptr + ADDR_W'(COLUMNS);

    always_comb begin
        o_mem.we    = 1'b0;
        o_mem.waddr = r_ptr;
        o_mem.wdata = {r_fill_attr, BLANK_CHAR};
        o_mem.raddr = (r_state == S_IDLE) ? ADDR_W'(i_cell_index) : src;
        if (r_wr_pend) begin
            o_mem.we    = 1'b1;
            o_mem.waddr = r_wr_addr;
            o_mem.wdata = i_rdata;
        end else if (r_state == S_FILL) begin
            o_mem.we = 1'b1;
        end else if (in_acc && i_mode == MODE_PUT && put.we) begin
            o_mem.we    = 1'b1;
            o_mem.waddr = put.waddr;
            o_mem.wdata = {i_attr, i_char_code};
        end
    end

    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_wr_pend   = 1'b0;
        n_wr_addr   = r_wr_addr;
        n_init      = r_init;
        n_fill_attr = r_fill_attr;
        n_col       = r_col;
        n_row       = r_row;
        n_rd_ok     = r_rd_ok;
        n_data      = r_data;
        n_out_vld   = r_out_vld && i_out_stall;
        n_pos       = r_pos;
        n_out_data  = r_out_data;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_data = '0;
                    case (i_mode)
                        MODE_PUT: begin
                            n_col = put.col;
                            n_row = put.row;
                            if (put.scroll) begin
                                n_state     = S_COPY;
                                n_ptr       = '0;
                                n_fill_attr = i_attr;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        MODE_CLEAR: begin
                            n_col       = '0;
                            n_row       = '0;
                            n_ptr       = '0;
                            n_fill_attr = i_attr;
                            n_state     = S_FILL;
                        end
                        MODE_READ: begin
                            n_rd_ok = in_range;
                            n_state = S_RDWT;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_COPY: begin
                n_wr_pend = 1'b1;
                n_wr_addr = r_ptr;
                if (r_ptr == ADDR_W'(LAST_BASE - 1)) begin
                    n_ptr   = ADDR_W'(LAST_BASE);
                    n_state = S_FILL;
                end else begin
                    n_ptr = ptr_inc;
                end
            end
            S_FILL: begin
                if (!r_wr_pend) begin
                    if (r_ptr == ADDR_W'(CELLS - 1)) begin
                        n_state = r_init ? S_IDLE : S_DONE;
                        n_init  = 1'b0;
                    end else begin
                        n_ptr = ptr_inc;
                    end
                end
            end
            S_RDWT: begin
                n_data  = r_rd_ok ? i_rdata : '0;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_vld  = 1'b1;
                    n_pos      = POS_W'(int'(r_row) * COLUMNS + int'(r_col));
                    n_out_data = r_data;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_ptr       <= '0;
            r_wr_pend   <= 1'b0;
            r_init      <= 1'b1;
            r_fill_attr <= ATTR_RESET;
            r_col       <= '0;
            r_row       <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_wr_pend   <= n_wr_pend;
            r_init      <= n_init;
            r_fill_attr <= n_fill_attr;
            r_col       <= n_col;
            r_row       <= n_row;
            r_out_vld   <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_addr  <= n_wr_addr;
        r_rd_ok    <= n_rd_ok;
        r_data     <= n_data;
        r_pos      <= n_pos;
        r_out_data <= n_out_data;
    end

    assign o_out_valid       = r_out_vld;
    assign o_cursor_position = r_pos;
    assign o_cell_data       = r_out_data;

endmodule

// ----- sv/text_console_writer_unit.sv -----
// Text console writer top level: APB attribute register, item sequencer and screen store.
// Depends on tcw_pkg, tcw_seq, tcw_cursor and tcw_ram.
//
// An 80x25 console of 16-bit cells (attribute high byte, character low byte) held in
// one RAM with one write and one registered read port, swept by a single address
// counter. A put item without scroll and an item of an unused mode pass from acceptance
// to the result register through the done state, a read item through the read-wait and
// done states. A put that scrolls copies 1920 cells, one cell a cycle through the RAM,
// then blank-fills the 80 cells of the last row. A clear writes 2000 blank cells, one
// cell per cycle. After reset a blanking pass writes all 2000 cells with the
// reset attribute and takes no item until it ends; register writes are taken always.
// Input is stalled while an item is at work, and a finished result can wait in the
// output register while the next item is accepted.
module text_console_writer_unit
    import tcw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [MODE_W-1:0]  i_mode,
    input  logic [CHAR_W-1:0]  i_char_code,
    input  logic [IDX_W-1:0]   i_cell_index,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [POS_W-1:0]   o_cursor_position,
    output logic [DATA_W-1:0]  o_cell_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]   pwdata,
    output logic [APB_W-1:0]   prdata,
    output logic               pready
);

    logic [ATTR_W-1:0] r_attr;
    t_mem_req          w_mem;
    logic [DATA_W-1:0] w_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= ATTR_RESET;
        end else if (psel && penable && pwrite && paddr == REG_ATTR) begin
            r_attr <= pwdata[ATTR_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == REG_ATTR) ? {(APB_W - ATTR_W)'(0), r_attr} : '0;

    tcw_seq u_seq (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_mode            (i_mode),
        .i_char_code       (i_char_code),
        .i_cell_index      (i_cell_index),
        .i_attr            (r_attr),
        .o_mem             (w_mem),
        .i_rdata           (w_rdata),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_cursor_position (o_cursor_position),
        .o_cell_data       (o_cell_data)
    );

    tcw_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem.we),
        .i_waddr (w_mem.waddr),
        .i_wdata (w_mem.wdata),
        .i_raddr (w_mem.raddr),
        .o_rdata (w_rdata)
    );

    a_wr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem.we |-> (int'(w_mem.waddr) < CELLS))
        else $error("Store write outside the screen.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("Input not stalled after an item was accepted.");

    a_init_pass: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("Input not stalled during the blanking pass after reset.");

endmodule

// ----- sim/tb.sv -----
// Self-checking bench for text_console_writer_unit: put, clear and read items under
// random idling, checked against an in-bench console predictor and an APB attribute.
// Depends on tcw_pkg and the text_console_writer_unit RTL.
module tb;
    import tcw_pkg::*;

    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam int CYCLE_LIMIT     = 20000000;
    localparam int ITEMS_PER_PHASE = 330;
    localparam int PHASES          = 5;
    localparam int DRAIN_CYCLES    = 16;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [CHAR_W-1:0] code;
        logic [IDX_W-1:0]  index;
    } t_console_item;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] data;
    } t_console_result;

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_in_valid   = 1'b0;
    logic               o_in_stall;
    logic [MODE_W-1:0]  i_mode       = '0;
    logic [CHAR_W-1:0]  i_char_code  = '0;
    logic [IDX_W-1:0]   i_cell_index = '0;
    logic               o_out_valid;
    logic               i_out_stall  = 1'b0;
    logic [POS_W-1:0]   o_cursor_position;
    logic [DATA_W-1:0]  o_cell_data;
    logic               psel         = 1'b0;
    logic               penable      = 1'b0;
    logic               pwrite       = 1'b0;
    logic [PADDR_W-1:0] paddr        = '0;
    logic [APB_W-1:0]   pwdata       = '0;
    logic [APB_W-1:0]   prdata;
    logic               pready;

    text_console_writer_unit dut (.*);

    logic [DATA_W-1:0] screen_img [CELLS];
    int                cur_col;
    int                cur_row;
    logic [ATTR_W-1:0] attr_now;

    t_console_item   item_q [$];
    t_console_result cursor_cell_q [$];

    int queued_cnt  = 0;
    int taken_cnt   = 0;
    int checked_cnt = 0;
    int error_cnt   = 0;
    int scroll_cnt  = 0;
    int clear_cnt   = 0;
    int read_cnt    = 0;
    int cycle_cnt   = 0;
    bit took_last   = 1'b0;
    int gap_max     = 0;
    int stall_pct   = 0;
    int gap_left    = 0;
    int burst_left  = 0;
    int stall_left  = 0;
    bit stall_on    = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void flag_mismatch(input string msg);
        error_cnt++;
        if (error_cnt <= 10) begin
            $display("tb: mismatch at cycle %0d: %s", cycle_cnt, msg);
        end
    endfunction

    function automatic t_console_result console_apply(input t_console_item it);
        t_console_result r;
        r.data = '0;
        case (it.mode)
            MODE_PUT: begin
                if (it.code == CH_BS && cur_col != 0) begin
                    cur_col--;
                end else if (it.code == CH_TAB) begin
                    cur_col = (cur_col + TAB_STEP) & ~(TAB_STEP - 1);
                end else if (it.code == CH_CR) begin
                    cur_col = 0;
                end else if (it.code == CH_LF) begin
                    cur_col = 0;
                    cur_row++;
                end else if (it.code >= PRINT_LO && it.code <= PRINT_HI) begin
                    screen_img[cur_row * COLUMNS + cur_col] = {attr_now, it.code};
                    cur_col++;
                end
                if (cur_col >= COLUMNS) begin
                    cur_col = 0;
                    cur_row++;
                end
                if (cur_row >= ROWS) begin
                    for (int i = 0; i < LAST_BASE; i++) screen_img[i] = screen_img[i + COLUMNS];
                    for (int i = LAST_BASE; i < CELLS; i++) screen_img[i] = {attr_now, BLANK_CHAR};
                    cur_row = ROWS - 1;
                    scroll_cnt++;
                end
            end
            MODE_CLEAR: begin
                for (int i = 0; i < CELLS; i++) screen_img[i] = {attr_now, BLANK_CHAR};
                cur_col = 0;
                cur_row = 0;
                clear_cnt++;
            end
            MODE_READ: begin
                read_cnt++;
                if (it.index < CELLS) r.data = screen_img[it.index];
            end
            default: ;
        endcase
        r.pos = POS_W'(cur_row * COLUMNS + cur_col);
        return r;
    endfunction

    function automatic void add_item(input logic [MODE_W-1:0] m, input logic [CHAR_W-1:0] c,
                                     input logic [IDX_W-1:0] x);
        item_q.push_back({m, c, x});
        queued_cnt++;
    endfunction

    // Mostly lines of text ending in a newline, with reads mixed in, plus stray bytes,
    // control codes, clears and the unused mode.
    function automatic void queue_random_text(input int n);
        int start;
        int len;
        int pick;
        start = queued_cnt;
        while (queued_cnt - start < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 110) : $urandom_range(0, 30);
                for (int k = 0; k < len; k++) begin
                    case ($urandom_range(0, 19))
                        0: add_item(MODE_PUT, CH_BS, IDX_W'($urandom));
                        1: add_item(MODE_PUT, CH_TAB, IDX_W'($urandom));
                        2, 3, 4: add_item(MODE_READ, CHAR_W'($urandom),
                                          IDX_W'($urandom_range(0, CELLS - 1)));
                        5: add_item(MODE_PUT, CHAR_W'($urandom), IDX_W'($urandom));
                        default: add_item(MODE_PUT, CHAR_W'($urandom_range(PRINT_LO, PRINT_HI)),
                                          IDX_W'($urandom));
                    endcase
                end
                case ($urandom_range(0, 4))
                    0, 1, 2: add_item(MODE_PUT, CH_LF, IDX_W'($urandom));
                    3: begin
                        add_item(MODE_PUT, CH_CR, IDX_W'($urandom));
                        add_item(MODE_PUT, CH_LF, IDX_W'($urandom));
                    end
                    default: ;
                endcase
            end else if (pick < 78) begin
                add_item(MODE_READ, CHAR_W'($urandom),
                         ($urandom_range(0, 5) == 0) ? IDX_W'($urandom_range(CELLS, 2**IDX_W - 1))
                                                     : IDX_W'($urandom_range(0, CELLS - 1)));
            end else if (pick < 86) begin
                add_item(MODE_PUT, CHAR_W'($urandom), IDX_W'($urandom));
            end else if (pick < 89) begin
                add_item(MODE_CLEAR, CHAR_W'($urandom), IDX_W'($urandom));
            end else if (pick < 92) begin
                add_item(MODE_SPARE, CHAR_W'($urandom), IDX_W'($urandom));
            end else begin
                case ($urandom_range(0, 3))
                    0: add_item(MODE_PUT, CH_BS, IDX_W'($urandom));
                    1: add_item(MODE_PUT, CH_TAB, IDX_W'($urandom));
                    2: add_item(MODE_PUT, CH_CR, IDX_W'($urandom));
                    default: add_item(MODE_PUT, CH_LF, IDX_W'($urandom));
                endcase
            end
        end
    endfunction

    task automatic wait_drained();
        do @(negedge i_clk); while (taken_cnt != queued_cnt || cursor_cell_q.size() != 0);
    endtask

    task automatic write_attr(input logic [ATTR_W-1:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_ATTR;
        pwdata  <= {(APB_W - ATTR_W)'($urandom), val};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        attr_now = val;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[ATTR_W-1:0] !== val) begin
            flag_mismatch($sformatf("attribute readback expected %h got %h",
                                    val, prdata[ATTR_W-1:0]));
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb: timeout after %0d cycles, %0d results still due",
                     cycle_cnt, cursor_cell_q.size());
            $display("tb: done, errors");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        t_console_item it;
        if (i_rst_n && (!i_in_valid || took_last)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (item_q.size() > 0) begin
                it = item_q.pop_front();
                i_mode       <= it.mode;
                i_char_code  <= it.code;
                i_cell_index <= it.index;
                i_in_valid   <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, gap_max);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
        end else begin
            stall_left = $urandom_range(1, 12);
            stall_on   = ($urandom_range(1, 100) <= stall_pct);
        end
        i_out_stall <= i_rst_n && stall_on;
    end

    always @(posedge i_clk) begin
        t_console_result want;
        if (!i_rst_n) begin
            took_last = 1'b0;
        end else begin
            took_last = i_in_valid && !o_in_stall;
            if (took_last) begin
                cursor_cell_q.push_back(console_apply({i_mode, i_char_code, i_cell_index}));
                taken_cnt++;
            end
            if (o_out_valid && !i_out_stall) begin
                if (cursor_cell_q.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result pos %0d data %h",
                                            o_cursor_position, o_cell_data));
                end else begin
                    want = cursor_cell_q.pop_front();
                    checked_cnt++;
                    if (o_cursor_position !== want.pos) begin
                        flag_mismatch($sformatf("result %0d cursor expected %0d got %0d",
                                                checked_cnt, want.pos, o_cursor_position));
                    end
                    if (o_cell_data !== want.data) begin
                        flag_mismatch($sformatf("result %0d cell expected %h got %h",
                                                checked_cnt, want.data, o_cell_data));
                    end
                end
            end
        end
    end

    initial begin
        logic [ATTR_W-1:0] attr_pick;
        attr_now = ATTR_RESET;
        cur_col  = 0;
        cur_row  = 0;
        for (int i = 0; i < CELLS; i++) screen_img[i] = {ATTR_RESET, BLANK_CHAR};
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The first phase runs on the reset attribute.
        gap_max   = 2;
        stall_pct = 20;
        add_item(MODE_READ, 8'hFF, IDX_W'(0));
        add_item(MODE_READ, 8'h00, IDX_W'(CELLS - 1));
        add_item(MODE_READ, 8'hA5, IDX_W'(2**IDX_W - 1));
        add_item(MODE_SPARE, 8'hFF, IDX_W'(2**IDX_W - 1));
        add_item(MODE_PUT, 8'h41, IDX_W'(2**IDX_W - 1));
        add_item(MODE_PUT, PRINT_LO, IDX_W'(0));
        add_item(MODE_PUT, PRINT_HI, IDX_W'(0));
        add_item(MODE_PUT, 8'h80, IDX_W'(0));
        add_item(MODE_PUT, 8'hFF, IDX_W'(0));
        add_item(MODE_PUT, 8'h00, IDX_W'(0));
        add_item(MODE_PUT, 8'h1F, IDX_W'(0));
        add_item(MODE_PUT, CH_BS, IDX_W'(0));
        add_item(MODE_PUT, CH_CR, IDX_W'(0));
        add_item(MODE_PUT, CH_BS, IDX_W'(0));
        add_item(MODE_PUT, CH_TAB, IDX_W'(0));
        add_item(MODE_PUT, CH_TAB, IDX_W'(0));
        add_item(MODE_READ, 8'h00, IDX_W'(0));
        add_item(MODE_READ, 8'h00, IDX_W'(1));
        add_item(MODE_READ, 8'h00, IDX_W'(2));
        add_item(MODE_PUT, CH_LF, IDX_W'(0));
        add_item(MODE_PUT, 8'h7E, IDX_W'(0));
        add_item(MODE_READ, 8'h00, IDX_W'(COLUMNS));
        add_item(MODE_CLEAR, 8'hFF, IDX_W'(2**IDX_W - 1));
        add_item(MODE_READ, 8'h00, IDX_W'(0));
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin attr_pick = 8'h00; gap_max = 0; stall_pct = 0;  end
                1: begin attr_pick = 8'hFF; gap_max = 4; stall_pct = 35; end
                2: begin attr_pick = 8'h5A; gap_max = 9; stall_pct = 70; end
                3: begin attr_pick = 8'hA5; gap_max = 1; stall_pct = 10; end
                default: begin
                    attr_pick = ATTR_W'($urandom);
                    gap_max   = 6;
                    stall_pct = 50;
                end
            endcase
            write_attr(attr_pick);
            queue_random_text(ITEMS_PER_PHASE);
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("tb: %0d items on %0d attribute settings: %0d reads, %0d clears, %0d scrolls",
                 taken_cnt, PHASES + 1, read_cnt, clear_cnt, scroll_cnt);
        $display("tb: %0d results compared, %0d mismatches", checked_cnt, error_cnt);
        if (error_cnt == 0 && cursor_cell_q.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/tcw_pkg.sv
sv/tcw_ram.sv
sv/tcw_cursor.sv
sv/tcw_seq.sv
sv/text_console_writer_unit.sv
sim/tb.sv
